FILE: src/pcw_pkg.sv
// Shared constants, register codes and helpers for the periodic cell wrap block.
package pcw_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FLIM_BITS = 30;
	localparam int FQ_W      = FLIM_BITS + 1;
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 31;
	localparam int DIV_LAT   = FLIM_BITS + 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_B_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_B_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_C_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_C_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_C_Z = 3'd5;

	// 10^6 = 2^6 * 15625
	localparam logic [63:0] DET_ODD = 64'd15625;

	// smallest diagonal product that is not bad: floor(2^(3F)/10^6) + 1
	function automatic logic [63:0] det_limit();
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = 64'd1;
		for (int i = 0; i < 3 * FRAC_BITS - 6; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= DET_ODD) begin
				r = r - DET_ODD;
				q[0] = 1'b1;
			end
		end
		return q + 64'd1;
	endfunction

	localparam logic [63:0] DET_LIMIT = det_limit();
	// the limit stays below 2^53 over the whole fraction range
	localparam int DL_BITS = 53;
	localparam int PL_BITS = 27;

endpackage

FILE: src/pcw_ifs.sv
// Stream and configuration channel interfaces of the periodic cell wrap block.
interface pcw_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               last_atom_in;
	modport source (output valid, pos_x, pos_y, pos_z, last_atom_in, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, last_atom_in, output ready);
endinterface

interface pcw_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] wrapped_x;
	logic signed [31:0] wrapped_y;
	logic signed [31:0] wrapped_z;
	logic               was_outside;
	logic               bad_cell;
	logic               last_atom_out;
	modport source (output valid, wrapped_x, wrapped_y, wrapped_z, was_outside, bad_cell,
		last_atom_out, input ready);
	modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, was_outside, bad_cell,
		last_atom_out, output ready);
endinterface

interface pcw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/pcw_fdiv.sv
// Pipelined floor divider, one quotient bit per stage, saturated to the fraction range.
module pcw_fdiv import pcw_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic signed [FQ_W-1:0]  quo
);

	logic                 neg_s1;
	logic [NUM_W-1:0]     rem_s1;
	logic                 neg_s2;
	logic                 sat_s2;
	logic [NUM_W-1:0]     rem_s2;
	logic                 neg_s3 [FLIM_BITS];
	logic                 sat_s3 [FLIM_BITS];
	logic [FLIM_BITS-1:0] q_s3   [FLIM_BITS];
	logic [NUM_W-1:0]     rem_s3 [FLIM_BITS-1];
	logic [FLIM_BITS-1:0] qs;

	// floor(n/d) for negative n is ~floor(~n/d)
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[NUM_W-1];
			rem_s1 <= num[NUM_W-1] ? ~num : num;
			neg_s2 <= neg_s1;
			rem_s2 <= rem_s1;
			sat_s2 <= rem_s1 >= (NUM_W'(den) << FLIM_BITS);
		end
	end

	for (genvar j = 0; j < FLIM_BITS; j++) begin : g_step
		localparam int K = FLIM_BITS - 1 - j;
		logic [NUM_W-1:0]     r_in;
		logic [NUM_W-1:0]     trial;
		logic [FLIM_BITS-1:0] q_in;
		logic                 n_in;
		logic                 s_in;
		if (j == 0) begin : g_first
			assign r_in = rem_s2;
			assign q_in = '0;
			assign n_in = neg_s2;
			assign s_in = sat_s2;
		end else begin : g_next
			assign r_in = rem_s3[j-1];
			assign q_in = q_s3[j-1];
			assign n_in = neg_s3[j-1];
			assign s_in = sat_s3[j-1];
		end
		assign trial = NUM_W'(den) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s3[j] <= n_in;
				sat_s3[j] <= s_in;
				q_s3[j]   <= (r_in >= trial) ? (q_in | (FLIM_BITS'(1) << K)) : q_in;
			end
		end
		if (j < FLIM_BITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s3[j] <= (r_in >= trial) ? (r_in - trial) : r_in;
				end
			end
		end
	end

	assign qs  = sat_s3[FLIM_BITS-1] ? '1 : q_s3[FLIM_BITS-1];
	assign quo = neg_s3[FLIM_BITS-1] ? ~{1'b0, qs} : {1'b0, qs};

endmodule

FILE: src/periodic_cell_wrap.sv
// Top level: maps atom positions into the central triclinic cell.
// One atom enters per cycle and passes through three chained floor dividers (gamma,
// beta, alpha) of 32 stages each, plus the multiply, wrap and output stages. While a
// result waits on the output the whole pipeline holds and no atom is taken. The
// bad-cell flag is worked out from the cell registers through the p_q, ph_q/pl_q and
// bad_q registers, so it is settled long before an atom accepted after a register
// write reaches the output.
module periodic_cell_wrap import pcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pcw_in_if.sink    in_ch,
	pcw_out_if.source out_ch,
	pcw_cfg_if.sink   cfg
);

	localparam int PROD_W = 33 + FRAC_BITS;
	localparam int SUM_W  = 35 + FRAC_BITS;
	localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(33'sh07fffffff);
	localparam logic signed [SUM_W-1:0] MINV = ~MAXV;
	localparam logic [30:0] ONE = 31'(64'd1 << FRAC_BITS);

	logic [30:0]        cell_a_x_q;
	logic signed [31:0] cell_b_x_q;
	logic [30:0]        cell_b_y_q;
	logic signed [31:0] cell_c_x_q;
	logic signed [31:0] cell_c_y_q;
	logic [30:0]        cell_c_z_q;

	logic [61:0]        p_q;
	logic               big_q;
	logic [56:0]        ph_q;
	logic [57:0]        pl_q;
	logic               bad_q;

	logic adv;

	logic               v_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic               last_s1;

	logic               v_s2    [DIV_LAT];
	logic signed [31:0] x_s2    [DIV_LAT];
	logic signed [31:0] y_s2    [DIV_LAT];
	logic               last_s2 [DIV_LAT];

	logic                  v_s3;
	logic signed [31:0]    x_s3, y_s3;
	logic signed [FQ_W-1:0] fg_s3;
	logic signed [62:0]    cyfg_s3;
	logic                  last_s3;

	logic                   v_s4    [DIV_LAT];
	logic signed [31:0]     x_s4    [DIV_LAT];
	logic signed [FQ_W-1:0] fg_s4   [DIV_LAT];
	logic                   last_s4 [DIV_LAT];

	logic                   v_s5;
	logic signed [31:0]     x_s5;
	logic signed [FQ_W-1:0] fg_s5, fb_s5;
	logic signed [62:0]     bxfb_s5, cxfg_s5;
	logic                   last_s5;

	logic                   v_s6    [DIV_LAT];
	logic signed [FQ_W-1:0] fg_s6   [DIV_LAT];
	logic signed [FQ_W-1:0] fb_s6   [DIV_LAT];
	logic                   last_s6 [DIV_LAT];

	logic                    v_s7;
	logic signed [PROD_W-1:0] pax_s7, pbx_s7, pcx_s7, pby_s7, pcy_s7, pcz_s7;
	logic                    outside_s7;
	logic                    last_s7;

	logic               v_s8;
	logic signed [31:0] wx_s8, wy_s8, wz_s8;
	logic               outside_s8, bad_s8, last_s8;

	logic signed [NUM_W-1:0] num_g, num_b, num_a;
	logic signed [FQ_W-1:0]  fg, fb, fa;
	logic signed [FQ_W-1:0]  fa_w, fb_w, fg_w;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] s;
		s = v >>> FRAC_BITS;
		if (s > MAXV) begin
			s = MAXV;
		end else if (s < MINV) begin
			s = MINV;
		end
		return s[31:0];
	endfunction

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_a_x_q <= ONE;
			cell_b_x_q <= '0;
			cell_b_y_q <= ONE;
			cell_c_x_q <= '0;
			cell_c_y_q <= '0;
			cell_c_z_q <= ONE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CELL_A_X: cell_a_x_q <= cfg.data[30:0];
				REG_CELL_B_X: cell_b_x_q <= cfg.data;
				REG_CELL_B_Y: cell_b_y_q <= cfg.data[30:0];
				REG_CELL_C_X: cell_c_x_q <= cfg.data;
				REG_CELL_C_Y: cell_c_y_q <= cfg.data;
				REG_CELL_C_Z: cell_c_z_q <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	// bad cell: a*by*cz below the limit, split to keep the multipliers narrow
	always_ff @(posedge clk) begin
		p_q   <= cell_a_x_q * cell_b_y_q;
		big_q <= {2'b0, p_q} >= DET_LIMIT;
		ph_q  <= p_q[DL_BITS-1:PL_BITS] * cell_c_z_q;
		pl_q  <= p_q[PL_BITS-1:0] * cell_c_z_q;
		bad_q <= (cell_c_z_q == '0) ||
			(!big_q && (({27'b0, ph_q, {PL_BITS{1'b0}}} + 111'(pl_q)) < 111'(DET_LIMIT)));
	end

	// whole pipeline advances together
	assign adv         = !v_s8 || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				v_s2[i] <= 1'b0;
				v_s4[i] <= 1'b0;
				v_s6[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= in_ch.valid;
			v_s2[0] <= v_s1;
			v_s4[0] <= v_s3;
			v_s6[0] <= v_s5;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_s2[i] <= v_s2[i-1];
				v_s4[i] <= v_s4[i-1];
				v_s6[i] <= v_s6[i-1];
			end
			v_s3 <= v_s2[DIV_LAT-1];
			v_s5 <= v_s4[DIV_LAT-1];
			v_s7 <= v_s6[DIV_LAT-1];
			v_s8 <= v_s7;
		end
	end

	// gamma
	assign num_g = NUM_W'(z_s1) <<< FRAC_BITS;
	pcw_fdiv u_div_g (.clk(clk), .en(adv), .num(num_g), .den(cell_c_z_q), .quo(fg));

	// beta
	assign num_b = (NUM_W'(y_s3) <<< FRAC_BITS) - NUM_W'(cyfg_s3);
	pcw_fdiv u_div_b (.clk(clk), .en(adv), .num(num_b), .den(cell_b_y_q), .quo(fb));

	// alpha
	assign num_a = (NUM_W'(x_s5) <<< FRAC_BITS) - NUM_W'(bxfb_s5) - NUM_W'(cxfg_s5);
	pcw_fdiv u_div_a (.clk(clk), .en(adv), .num(num_a), .den(cell_a_x_q), .quo(fa));

	assign fa_w = fa;
	assign fb_w = fb_s6[DIV_LAT-1];
	assign fg_w = fg_s6[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= in_ch.pos_x;
			y_s1    <= in_ch.pos_y;
			z_s1    <= in_ch.pos_z;
			last_s1 <= in_ch.last_atom_in;

			x_s2[0]    <= x_s1;
			y_s2[0]    <= y_s1;
			last_s2[0] <= last_s1;
			x_s4[0]    <= x_s3;
			fg_s4[0]   <= fg_s3;
			last_s4[0] <= last_s3;
			fg_s6[0]   <= fg_s5;
			fb_s6[0]   <= fb_s5;
			last_s6[0] <= last_s5;
			for (int i = 1; i < DIV_LAT; i++) begin
				x_s2[i]    <= x_s2[i-1];
				y_s2[i]    <= y_s2[i-1];
				last_s2[i] <= last_s2[i-1];
				x_s4[i]    <= x_s4[i-1];
				fg_s4[i]   <= fg_s4[i-1];
				last_s4[i] <= last_s4[i-1];
				fg_s6[i]   <= fg_s6[i-1];
				fb_s6[i]   <= fb_s6[i-1];
				last_s6[i] <= last_s6[i-1];
			end

			x_s3    <= x_s2[DIV_LAT-1];
			y_s3    <= y_s2[DIV_LAT-1];
			last_s3 <= last_s2[DIV_LAT-1];
			fg_s3   <= fg;
			cyfg_s3 <= cell_c_y_q * fg;

			x_s5    <= x_s4[DIV_LAT-1];
			last_s5 <= last_s4[DIV_LAT-1];
			fg_s5   <= fg_s4[DIV_LAT-1];
			fb_s5   <= fb;
			bxfb_s5 <= cell_b_x_q * fb;
			cxfg_s5 <= cell_c_x_q * fg_s4[DIV_LAT-1];

			// keep the floor fraction of each coordinate
			last_s7    <= last_s6[DIV_LAT-1];
			outside_s7 <= (|fa_w[FQ_W-1:FRAC_BITS]) || (|fb_w[FQ_W-1:FRAC_BITS]) ||
				(|fg_w[FQ_W-1:FRAC_BITS]);
			pax_s7 <= $signed({1'b0, cell_a_x_q}) * $signed({1'b0, fa_w[FRAC_BITS-1:0]});
			pbx_s7 <= cell_b_x_q * $signed({1'b0, fb_w[FRAC_BITS-1:0]});
			pcx_s7 <= cell_c_x_q * $signed({1'b0, fg_w[FRAC_BITS-1:0]});
			pby_s7 <= $signed({1'b0, cell_b_y_q}) * $signed({1'b0, fb_w[FRAC_BITS-1:0]});
			pcy_s7 <= cell_c_y_q * $signed({1'b0, fg_w[FRAC_BITS-1:0]});
			pcz_s7 <= $signed({1'b0, cell_c_z_q}) * $signed({1'b0, fg_w[FRAC_BITS-1:0]});

			last_s8    <= last_s7;
			bad_s8     <= bad_q;
			outside_s8 <= bad_q ? 1'b0 : outside_s7;
			wx_s8      <= bad_q ? '0 : sat32(sum_x);
			wy_s8      <= bad_q ? '0 : sat32(sum_y);
			wz_s8      <= bad_q ? '0 : sat32(sum_z);
		end
	end

	assign sum_x = SUM_W'(pax_s7) + SUM_W'(pbx_s7) + SUM_W'(pcx_s7);
	assign sum_y = SUM_W'(pby_s7) + SUM_W'(pcy_s7);
	assign sum_z = SUM_W'(pcz_s7);

	assign out_ch.valid         = v_s8;
	assign out_ch.wrapped_x     = wx_s8;
	assign out_ch.wrapped_y     = wy_s8;
	assign out_ch.wrapped_z     = wz_s8;
	assign out_ch.was_outside   = outside_s8;
	assign out_ch.bad_cell      = bad_s8;
	assign out_ch.last_atom_out = last_s8;

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while output beat stalled");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input refused with empty output");

	a_bad_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.bad_cell) |-> (out_ch.wrapped_x == '0 &&
		out_ch.wrapped_y == '0 && out_ch.wrapped_z == '0 && !out_ch.was_outside))
		else $error("bad cell beat carries coordinates");
`endif

endmodule
